// ===== src/sipd_pkg.sv =====
// sipd_pkg: shared types, field widths and register codes for the
// shape indexed pixel difference core; no dependencies
package sipd_pkg;

    localparam int OFF_W      = 16;
    localparam int LMK_W      = 18;
    localparam int BOX_W      = 13;
    localparam int AFF_W      = 20;
    localparam int DIM_W      = 10;
    localparam int PADDR_W    = 18;
    localparam int PIX_W      = 8;
    localparam int DIFF_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int SCL_W  = OFF_W + BOX_W + 1;
    localparam int PRD_W  = AFF_W + SCL_W;
    localparam int SUM_W  = PRD_W + 2;
    localparam int FRAC   = 31;
    localparam int Q_W    = SUM_W - FRAC;
    localparam int TR_SH  = 15;
    localparam int LMK_SH = 27;
    localparam int PT_LAT = 5;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_FEATURE = 1'b1;

    localparam logic signed [AFF_W-1:0] AFF_ONE  = 20'sd65536;
    localparam logic signed [AFF_W-1:0] AFF_ZERO = 20'sd0;
    localparam logic [DIM_W-1:0]        DIM_RST  = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AFFINE_XX = 3'd0,
        CFG_AFFINE_YX = 3'd1,
        CFG_AFFINE_TX = 3'd2,
        CFG_AFFINE_XY = 3'd3,
        CFG_AFFINE_YY = 3'd4,
        CFG_AFFINE_TY = 3'd5,
        CFG_IMAGE_COLS = 3'd6,
        CFG_IMAGE_ROWS = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [AFF_W-1:0] xx;
        logic signed [AFF_W-1:0] yx;
        logic signed [AFF_W-1:0] tx;
        logic signed [AFF_W-1:0] xy;
        logic signed [AFF_W-1:0] yy;
        logic signed [AFF_W-1:0] ty;
    } t_affine;

    typedef struct packed {
        logic valid;
        logic feat;
        logic wr_ok;
    } t_slot;

endpackage

// ===== src/sipd_point.sv =====
// sipd_point: five stage pipeline mapping one normalised offset to a clamped
// pixel coordinate (scale, affine products, sums, truncation and clamp)
// depends on sipd_pkg
module sipd_point #(
    parameter int XW = 9,
    parameter int YW = 9
) (
    input  logic                                  i_clk,
    input  logic signed [sipd_pkg::OFF_W-1:0]     i_off_x,
    input  logic signed [sipd_pkg::OFF_W-1:0]     i_off_y,
    input  logic        [sipd_pkg::BOX_W-1:0]     i_box_w,
    input  logic        [sipd_pkg::BOX_W-1:0]     i_box_h,
    input  logic signed [sipd_pkg::LMK_W-1:0]     i_lmk_x,
    input  logic signed [sipd_pkg::LMK_W-1:0]     i_lmk_y,
    input  sipd_pkg::t_affine                     i_aff,
    input  logic        [XW-1:0]                  i_xmax,
    input  logic        [YW-1:0]                  i_ymax,
    output logic        [XW-1:0]                  o_x,
    output logic        [YW-1:0]                  o_y
);
    import sipd_pkg::*;

    logic signed [SCL_W-1:0] r_sx, r_sy;
    logic signed [LMK_W-1:0] r_lx1, r_ly1, r_lx2, r_ly2;
    logic signed [PRD_W-1:0] r_pxx, r_pyx, r_pxy, r_pyy;
    logic signed [SUM_W-1:0] r_ax, r_ay, r_bx, r_by, r_tsx, r_tsy;
    logic        [Q_W-1:0]   n_qx, n_qy;
    logic        [XW-1:0]    r_x;
    logic        [YW-1:0]    r_y;

    function automatic logic [Q_W-1:0] trunc_clamp(input logic signed [SUM_W-1:0] v,
                                                   input logic [Q_W-1:0] lim);
        logic signed [Q_W-1:0] q;
        logic [Q_W-1:0]        res;
        q = Q_W'(v >>> FRAC) + Q_W'(v[SUM_W-1] && (v[FRAC-1:0] != '0));
        if (q < 0) begin
            res = '0;
        end else if (q > $signed(lim)) begin
            res = lim;
        end else begin
            res = q;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        // scale offsets by the box size
        r_sx  <= SCL_W'(i_off_x) * SCL_W'($signed({1'b0, i_box_w}));
        r_sy  <= SCL_W'(i_off_y) * SCL_W'($signed({1'b0, i_box_h}));
        r_lx1 <= i_lmk_x;
        r_ly1 <= i_lmk_y;
        // affine products
        r_pxx <= PRD_W'(i_aff.xx) * PRD_W'(r_sx);
        r_pyx <= PRD_W'(i_aff.yx) * PRD_W'(r_sy);
        r_pxy <= PRD_W'(i_aff.xy) * PRD_W'(r_sx);
        r_pyy <= PRD_W'(i_aff.yy) * PRD_W'(r_sy);
        r_lx2 <= r_lx1;
        r_ly2 <= r_ly1;
        // partial sums
        r_ax  <= SUM_W'(r_pxx) + SUM_W'(r_pyx);
        r_ay  <= SUM_W'(r_pxy) + SUM_W'(r_pyy);
        r_bx  <= (SUM_W'(i_aff.tx) <<< TR_SH) + (SUM_W'(r_lx2) <<< LMK_SH);
        r_by  <= (SUM_W'(i_aff.ty) <<< TR_SH) + (SUM_W'(r_ly2) <<< LMK_SH);
        r_tsx <= r_ax + r_bx;
        r_tsy <= r_ay + r_by;
        r_x   <= n_qx[XW-1:0];
        r_y   <= n_qy[YW-1:0];
    end

    always_comb begin
        n_qx = trunc_clamp(r_tsx, Q_W'(i_xmax));
        n_qy = trunc_clamp(r_tsy, Q_W'(i_ymax));
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== src/shape_indexed_pixel_difference_core.sv =====
// shape_indexed_pixel_difference_core: pixel write items one per cycle while
// busy is low. busy is high for the cycle after a feature is accepted, leaving
// an idle slot for the second read of the single-port image memory.
// each feature gives a result strobe after its two reads; writes give no result.
// reset clears control and configuration; the image memory is not cleared.
// the receiver cannot stall; each result is shown for exactly one cycle
module shape_indexed_pixel_difference_core #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic        [sipd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [sipd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                   i_req_type,
    input  logic        [sipd_pkg::PADDR_W-1:0]    i_pixel_addr,
    input  logic        [sipd_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic signed [sipd_pkg::OFF_W-1:0]      i_start_off_x,
    input  logic signed [sipd_pkg::OFF_W-1:0]      i_start_off_y,
    input  logic signed [sipd_pkg::OFF_W-1:0]      i_end_off_x,
    input  logic signed [sipd_pkg::OFF_W-1:0]      i_end_off_y,
    input  logic signed [sipd_pkg::LMK_W-1:0]      i_landmark_x,
    input  logic signed [sipd_pkg::LMK_W-1:0]      i_landmark_y,
    input  logic        [sipd_pkg::BOX_W-1:0]      i_box_width,
    input  logic        [sipd_pkg::BOX_W-1:0]      i_box_height,
    output logic                                   o_valid,
    output logic signed [sipd_pkg::DIFF_W-1:0]     o_pixel_diff
);
    import sipd_pkg::*;

    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int STORE = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(STORE);
    localparam int SLOTS = PT_LAT + 1;

    t_affine                   r_aff;
    logic [DIM_W-1:0]          r_image_cols, r_image_rows;
    logic [XW-1:0]             r_xmax, n_xmax;
    logic [YW-1:0]             r_ymax, n_ymax;

    logic                      accept;
    logic                      r_busy;
    t_slot                     r_slot [SLOTS];
    logic [AW-1:0]             r_wr_addr [SLOTS];
    logic [PIX_W-1:0]          r_wr_data [SLOTS];
    logic [AW+PADDR_W-1:0]     wa_ext;

    logic [XW-1:0]             x_a, x_b;
    logic [YW-1:0]             y_a, y_b;
    logic [AW-1:0]             r_addr_a, r_addr_b, r_addr_b_hold;

    logic                      n_rd_a, n_we;
    logic                      r_ph_b, r_got_b;
    logic [AW-1:0]             mem_addr;
    logic [PIX_W-1:0]          mem [STORE];
    logic [PIX_W-1:0]          r_rd_data, r_pix_a;
    logic                      r_valid;
    logic signed [DIFF_W-1:0]  r_diff;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aff.xx     <= AFF_ONE;
            r_aff.yx     <= AFF_ZERO;
            r_aff.tx     <= AFF_ZERO;
            r_aff.xy     <= AFF_ZERO;
            r_aff.yy     <= AFF_ONE;
            r_aff.ty     <= AFF_ZERO;
            r_image_cols <= DIM_RST;
            r_image_rows <= DIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AFFINE_XX:  r_aff.xx     <= i_cfg_data;
                CFG_AFFINE_YX:  r_aff.yx     <= i_cfg_data;
                CFG_AFFINE_TX:  r_aff.tx     <= i_cfg_data;
                CFG_AFFINE_XY:  r_aff.xy     <= i_cfg_data;
                CFG_AFFINE_YY:  r_aff.yy     <= i_cfg_data;
                CFG_AFFINE_TY:  r_aff.ty     <= i_cfg_data;
                CFG_IMAGE_COLS: r_image_cols <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_ROWS: r_image_rows <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // largest legal coordinate from the image size
    always_comb begin
        if (r_image_cols == '0) begin
            n_xmax = '0;
        end else if (32'(r_image_cols) > MAX_COLS) begin
            n_xmax = XW'(MAX_COLS - 1);
        end else begin
            n_xmax = XW'(r_image_cols - 1'b1);
        end
        if (r_image_rows == '0) begin
            n_ymax = '0;
        end else if (32'(r_image_rows) > MAX_ROWS) begin
            n_ymax = YW'(MAX_ROWS - 1);
        end else begin
            n_ymax = YW'(r_image_rows - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_xmax <= n_xmax;
        r_ymax <= n_ymax;
    end

    // transaction tracking alongside the coordinate pipeline
    assign accept = start && !busy;
    assign busy   = r_busy;
    assign wa_ext = (AW+PADDR_W)'(i_pixel_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else begin
            r_busy         <= accept && (i_req_type == REQ_FEATURE);
            r_slot[0].valid <= accept;
            r_slot[0].feat  <= (i_req_type == REQ_FEATURE);
            r_slot[0].wr_ok <= (wa_ext < (AW+PADDR_W)'(STORE));
            for (int i = 1; i < SLOTS; i++) begin
                r_slot[i] <= r_slot[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr[0] <= wa_ext[AW-1:0];
        r_wr_data[0] <= i_pixel_value;
        for (int i = 1; i < SLOTS; i++) begin
            r_wr_addr[i] <= r_wr_addr[i-1];
            r_wr_data[i] <= r_wr_data[i-1];
        end
    end

    sipd_point #(.XW(XW), .YW(YW)) u_pt_a (
        .i_clk   (i_clk),
        .i_off_x (i_start_off_x),
        .i_off_y (i_start_off_y),
        .i_box_w (i_box_width),
        .i_box_h (i_box_height),
        .i_lmk_x (i_landmark_x),
        .i_lmk_y (i_landmark_y),
        .i_aff   (r_aff),
        .i_xmax  (r_xmax),
        .i_ymax  (r_ymax),
        .o_x     (x_a),
        .o_y     (y_a)
    );

    sipd_point #(.XW(XW), .YW(YW)) u_pt_b (
        .i_clk   (i_clk),
        .i_off_x (i_end_off_x),
        .i_off_y (i_end_off_y),
        .i_box_w (i_box_width),
        .i_box_h (i_box_height),
        .i_lmk_x (i_landmark_x),
        .i_lmk_y (i_landmark_y),
        .i_aff   (r_aff),
        .i_xmax  (r_xmax),
        .i_ymax  (r_ymax),
        .o_x     (x_b),
        .o_y     (y_b)
    );

    // linear addresses
    always_ff @(posedge i_clk) begin
        r_addr_a      <= AW'(y_a) * AW'(MAX_COLS) + AW'(x_a);
        r_addr_b      <= AW'(y_b) * AW'(MAX_COLS) + AW'(x_b);
        r_addr_b_hold <= r_addr_b;
    end

    // single-port image memory: writes, first read, then second read in idle slot
    always_comb begin
        n_rd_a = r_slot[SLOTS-1].valid && r_slot[SLOTS-1].feat;
        n_we   = r_slot[SLOTS-1].valid && !r_slot[SLOTS-1].feat && r_slot[SLOTS-1].wr_ok;
        if (r_ph_b) begin
            mem_addr = r_addr_b_hold;
        end else if (n_we) begin
            mem_addr = r_wr_addr[SLOTS-1];
        end else begin
            mem_addr = r_addr_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[mem_addr] <= r_wr_data[SLOTS-1];
        end else begin
            r_rd_data <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_b  <= 1'b0;
            r_got_b <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_ph_b  <= n_rd_a;
            r_got_b <= r_ph_b;
            r_valid <= r_got_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph_b) begin
            r_pix_a <= r_rd_data;
        end
        r_diff <= $signed({1'b0, r_pix_a}) - $signed({1'b0, r_rd_data});
    end

    assign o_valid      = r_valid;
    assign o_pixel_diff = r_diff;

endmodule

// ===== src/sipd_checker.sv =====
// sipd_checker: port level checks for the shape indexed pixel difference core
// and the bind that attaches them; depends on sipd_pkg
module sipd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_req_type,
    input logic                               o_valid,
    input logic signed [sipd_pkg::DIFF_W-1:0] o_pixel_diff
);
    import sipd_pkg::*;

    logic feat_acc;
    assign feat_acc = start && !busy && (i_req_type == REQ_FEATURE);

    // a feature transaction blocks the next cycle
    a_busy_after_feat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        feat_acc |=> busy)
        else $error("busy not raised after feature transaction");

    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // fixed latency from feature transaction to result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        feat_acc |-> ##9 o_valid)
        else $error("result strobe missing after feature transaction");

    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes in consecutive cycles");

    a_diff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_diff != 9'h100))
        else $error("pixel difference out of range");

endmodule

bind shape_indexed_pixel_difference_core sipd_checker u_sipd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req_type   (i_req_type),
    .o_valid      (o_valid),
    .o_pixel_diff (o_pixel_diff)
);

// ===== tb/sipd_tb_pkg.sv =====
// sipd_tb_pkg: request record and pixel difference scoreboard for the
// shape indexed pixel difference core testbench; depends on sipd_pkg
package sipd_tb_pkg;
    import sipd_pkg::*;

    localparam int     IMG_COLS    = 512;
    localparam int     IMG_ROWS    = 512;
    localparam int     IMG_SIZE    = IMG_COLS * IMG_ROWS;
    localparam longint Q31_UNIT    = 64'sd2147483648;

    typedef struct {
        logic                     req_type;
        logic [PADDR_W-1:0]       pixel_addr;
        logic [PIX_W-1:0]         pixel_value;
        logic signed [OFF_W-1:0]  s_off_x;
        logic signed [OFF_W-1:0]  s_off_y;
        logic signed [OFF_W-1:0]  e_off_x;
        logic signed [OFF_W-1:0]  e_off_y;
        logic signed [LMK_W-1:0]  lmk_x;
        logic signed [LMK_W-1:0]  lmk_y;
        logic [BOX_W-1:0]         box_w;
        logic [BOX_W-1:0]         box_h;
    } t_pix_req;

    class diff_scoreboard;
        t_affine                  aff;
        logic [DIM_W-1:0]         cols_reg;
        logic [DIM_W-1:0]         rows_reg;
        bit [PIX_W-1:0]           image [IMG_SIZE];
        bit                       loaded [IMG_SIZE];
        logic signed [DIFF_W-1:0] pending_diffs [$];
        int unsigned              errors;

        function new();
            aff      = '{AFF_ONE, AFF_ZERO, AFF_ZERO, AFF_ZERO, AFF_ONE, AFF_ZERO};
            cols_reg = DIM_RST;
            rows_reg = DIM_RST;
            errors   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_AFFINE_XX:  aff.xx = data;
                CFG_AFFINE_YX:  aff.yx = data;
                CFG_AFFINE_TX:  aff.tx = data;
                CFG_AFFINE_XY:  aff.xy = data;
                CFG_AFFINE_YY:  aff.yy = data;
                CFG_AFFINE_TY:  aff.ty = data;
                CFG_IMAGE_COLS: cols_reg = data[DIM_W-1:0];
                CFG_IMAGE_ROWS: rows_reg = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip_dim(logic [DIM_W-1:0] dim, int lim);
            longint d;
            d = longint'(dim);
            if (d < 1) d = 1;
            if (d > lim) d = lim;
            return d;
        endfunction

        // store index of the pixel that one normalised offset lands on
        function int point_addr(logic signed [OFF_W-1:0] ox, logic signed [OFF_W-1:0] oy,
                                t_pix_req r);
            longint sx, sy, px, py, nc, nr;
            sx = longint'(ox) * longint'(r.box_w);
            sy = longint'(oy) * longint'(r.box_h);
            px = longint'(aff.xx) * sx + longint'(aff.yx) * sy
               + longint'(aff.tx) * 32768 + longint'(r.lmk_x) * 134217728;
            py = longint'(aff.xy) * sx + longint'(aff.yy) * sy
               + longint'(aff.ty) * 32768 + longint'(r.lmk_y) * 134217728;
            nc = clip_dim(cols_reg, IMG_COLS);
            nr = clip_dim(rows_reg, IMG_ROWS);
            px = px / Q31_UNIT;
            py = py / Q31_UNIT;
            if (px < 0) px = 0;
            if (px > nc - 1) px = nc - 1;
            if (py < 0) py = 0;
            if (py > nr - 1) py = nr - 1;
            return int'(py * IMG_COLS + px);
        endfunction

        function bit is_loaded(int addr);
            return loaded[addr];
        endfunction

        function int pending_count();
            return pending_diffs.size();
        endfunction

        function void note_request(t_pix_req r);
            int a, b, d;
            logic signed [DIFF_W-1:0] e;
            if (r.req_type == REQ_WRITE) begin
                image[r.pixel_addr]  = r.pixel_value;
                loaded[r.pixel_addr] = 1'b1;
            end else begin
                a = point_addr(r.s_off_x, r.s_off_y, r);
                b = point_addr(r.e_off_x, r.e_off_y, r);
                d = int'(image[a]) - int'(image[b]);
                e = d[DIFF_W-1:0];
                pending_diffs = {pending_diffs, e};
            end
        endfunction

        function void check_diff(logic signed [DIFF_W-1:0] actual, longint stamp);
            logic signed [DIFF_W-1:0] want;
            if (pending_diffs.size() == 0) begin
                $display("%0d ns: unexpected pixel_diff, expected none, actual %0d",
                         stamp, actual);
                errors++;
            end else begin
                want = pending_diffs.pop_front();
                if (actual !== want) begin
                    $display("%0d ns: pixel_diff mismatch, expected %0d, actual %0d",
                             stamp, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/shape_indexed_pixel_difference_core_tb.sv =====
// shape_indexed_pixel_difference_core_tb: loads pixels and issues feature
// transactions under several affine and image size settings, checking every
// difference against the scoreboard; depends on sipd_pkg and sipd_tb_pkg
module shape_indexed_pixel_difference_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sipd_pkg::*;
    import sipd_tb_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_req_type;
    logic [PADDR_W-1:0]       i_pixel_addr;
    logic [PIX_W-1:0]         i_pixel_value;
    logic signed [OFF_W-1:0]  i_start_off_x;
    logic signed [OFF_W-1:0]  i_start_off_y;
    logic signed [OFF_W-1:0]  i_end_off_x;
    logic signed [OFF_W-1:0]  i_end_off_y;
    logic signed [LMK_W-1:0]  i_landmark_x;
    logic signed [LMK_W-1:0]  i_landmark_y;
    logic [BOX_W-1:0]         i_box_width;
    logic [BOX_W-1:0]         i_box_height;
    logic                     o_valid;
    logic signed [DIFF_W-1:0] o_pixel_diff;

    diff_scoreboard sb;
    int             burst_left  = 0;
    int             idle_cycles = 0;
    int             sent_items  = 0;
    int             recent_pts [$];

    shape_indexed_pixel_difference_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_pixel_addr  (i_pixel_addr),
        .i_pixel_value (i_pixel_value),
        .i_start_off_x (i_start_off_x),
        .i_start_off_y (i_start_off_y),
        .i_end_off_x   (i_end_off_x),
        .i_end_off_y   (i_end_off_y),
        .i_landmark_x  (i_landmark_x),
        .i_landmark_y  (i_landmark_y),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .o_valid       (o_valid),
        .o_pixel_diff  (o_pixel_diff)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_diff(o_pixel_diff, $time);
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1 || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic drive_req(input t_pix_req r);
        @(negedge i_clk);
        i_req_type    <= r.req_type;
        i_pixel_addr  <= r.pixel_addr;
        i_pixel_value <= r.pixel_value;
        i_start_off_x <= r.s_off_x;
        i_start_off_y <= r.s_off_y;
        i_end_off_x   <= r.e_off_x;
        i_end_off_y   <= r.e_off_y;
        i_landmark_x  <= r.lmk_x;
        i_landmark_y  <= r.lmk_y;
        i_box_width   <= r.box_w;
        i_box_height  <= r.box_h;
        start         <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_request(r);
        sent_items++;
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // bursts of random length, mostly separated by short gaps
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 7));
        end
        burst_left--;
    endtask

    task automatic put_write(input int addr, input logic [PIX_W-1:0] value);
        t_pix_req r = '{default: '0};
        r.req_type    = REQ_WRITE;
        r.pixel_addr  = PADDR_W'(addr);
        r.pixel_value = value;
        pace();
        drive_req(r);
    endtask

    // any pixel the feature would read is loaded first, right ahead of it
    task automatic put_feature(input t_pix_req r);
        int a;
        int b;
        a = sb.point_addr(r.s_off_x, r.s_off_y, r);
        if (!sb.is_loaded(a)) put_write(a, PIX_W'($urandom));
        b = sb.point_addr(r.e_off_x, r.e_off_y, r);
        if (!sb.is_loaded(b)) put_write(b, PIX_W'($urandom));
        pace();
        drive_req(r);
        recent_pts = {recent_pts, a, b};
        while (recent_pts.size() > 16) void'(recent_pts.pop_front());
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_affine(input logic [AFF_W-1:0] xx, input logic [AFF_W-1:0] yx,
                              input logic [AFF_W-1:0] tx, input logic [AFF_W-1:0] xy,
                              input logic [AFF_W-1:0] yy, input logic [AFF_W-1:0] ty);
        cfg_write(CFG_AFFINE_XX, xx);
        cfg_write(CFG_AFFINE_YX, yx);
        cfg_write(CFG_AFFINE_TX, tx);
        cfg_write(CFG_AFFINE_XY, xy);
        cfg_write(CFG_AFFINE_YY, yy);
        cfg_write(CFG_AFFINE_TY, ty);
    endtask

    task automatic set_dims(input int cols, input int rows);
        cfg_write(CFG_IMAGE_COLS, CFG_DATA_W'(cols));
        cfg_write(CFG_IMAGE_ROWS, CFG_DATA_W'(rows));
    endtask

    function automatic t_pix_req make_feature(input int sx, input int sy, input int ex,
                                              input int ey, input int lx, input int ly,
                                              input int bw, input int bh);
        t_pix_req r = '{default: '0};
        r.req_type = REQ_FEATURE;
        r.s_off_x  = OFF_W'(sx);
        r.s_off_y  = OFF_W'(sy);
        r.e_off_x  = OFF_W'(ex);
        r.e_off_y  = OFF_W'(ey);
        r.lmk_x    = LMK_W'(lx);
        r.lmk_y    = LMK_W'(ly);
        r.box_w    = BOX_W'(bw);
        r.box_h    = BOX_W'(bh);
        return r;
    endfunction

    // weight within about +-1.5 in Q4.16
    function automatic logic [AFF_W-1:0] rand_weight();
        int w;
        w = int'($urandom_range(0, 196608)) - 98304;
        return w[AFF_W-1:0];
    endfunction

    function automatic t_pix_req random_feature();
        int mode;
        int lim;
        mode = $urandom_range(0, 9);
        lim  = (mode < 3) ? 4096 : 128;
        if (mode == 0)
            return make_feature($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom_range(1, 4096), $urandom_range(1, 4096));
        return make_feature($urandom, $urandom, $urandom, $urandom,
                            $urandom_range(0, IMG_COLS * 16 - 1),
                            $urandom_range(0, IMG_ROWS * 16 - 1),
                            $urandom_range(1, lim), $urandom_range(1, lim));
    endfunction

    // n counts every transaction sent, pixel loads for features included
    task automatic random_run(input int n);
        int addr;
        int stop_at;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 199) == 0) settle();
            if ($urandom_range(0, 99) < 35) begin
                if (recent_pts.size() != 0 && $urandom_range(0, 1) == 1)
                    addr = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
                else
                    addr = $urandom_range(0, IMG_SIZE - 1);
                put_write(addr, PIX_W'($urandom));
            end else begin
                put_feature(random_feature());
            end
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_AFFINE_XX;
        i_cfg_data    = '0;
        i_req_type    = REQ_WRITE;
        i_pixel_addr  = '0;
        i_pixel_value = '0;
        i_start_off_x = '0;
        i_start_off_y = '0;
        i_end_off_x   = '0;
        i_end_off_y   = '0;
        i_landmark_x  = '0;
        i_landmark_y  = '0;
        i_box_width   = '0;
        i_box_height  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: identity transform on a full size image
        put_write(0, 8'hFF);
        put_write(IMG_SIZE - 1, 8'h00);
        put_write(100 * IMG_COLS + 100, 8'h5A);
        put_feature(make_feature(0, 0, 0, 0, 100 * 16, 100 * 16, 1, 1));
        put_feature(make_feature(-32768, -32768, 32767, 32767, 0, 0, 4096, 4096));
        put_feature(make_feature(32767, 32767, -32768, -32768, 0, 0, 4096, 4096));
        put_feature(make_feature(0, 0, -32768, 32767, 131071, -131072, 4096, 4096));
        put_feature(make_feature(32767, -32768, 0, 0, -131072, 131071, 1, 1));
        // truncation toward zero on either side of a pixel boundary
        put_feature(make_feature(0, 0, 0, 0, -8, 8, 1, 1));
        put_feature(make_feature(-1, -1, 1, 1, 160, 160, 1, 1));
        put_feature(make_feature(0, 0, 0, 0, 8 * 16 + 15, 9 * 16 + 15, 1, 1));
        put_feature(make_feature(32767, 0, 0, 32767, 200 * 16, 300 * 16, 100, 60));
        put_write(100 * IMG_COLS + 100, 8'h01);
        put_feature(make_feature(0, 0, -32768, -32768, 100 * 16, 100 * 16, 4096, 4096));

        settle();
        set_affine(AFF_ONE, AFF_ZERO, AFF_ZERO, AFF_ZERO, AFF_ONE, AFF_ZERO);
        set_dims(512, 512);
        random_run(250);

        settle();
        set_affine(rand_weight(), rand_weight(), AFF_W'($urandom), rand_weight(),
                   rand_weight(), AFF_W'($urandom));
        set_dims($urandom_range(1, 512), $urandom_range(1, 512));
        random_run(250);

        // zero and oversize image dimensions against extreme weights
        settle();
        set_affine(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        set_dims(0, 1023);
        random_run(80);

        settle();
        set_affine(20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000);
        set_dims(1023, 0);
        random_run(80);

        settle();
        set_affine(rand_weight(), rand_weight(), AFF_W'($urandom), rand_weight(),
                   rand_weight(), AFF_W'($urandom));
        set_dims(1, 1);
        random_run(60);

        repeat (3) begin
            settle();
            if ($urandom_range(0, 1) == 1)
                set_affine(AFF_W'($urandom), AFF_W'($urandom), AFF_W'($urandom),
                           AFF_W'($urandom), AFF_W'($urandom), AFF_W'($urandom));
            else
                set_affine(rand_weight(), rand_weight(), AFF_W'($urandom), rand_weight(),
                           rand_weight(), AFF_W'($urandom));
            set_dims($urandom_range(0, 1023), $urandom_range(0, 1023));
            random_run(180);
        end

        settle();
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
